// ===== src/qpc_pkg.sv =====
// qpc_pkg: shared types and constants of the quintic path coefficient block
// no dependencies; used by quintic_path_coefficients and tb
`default_nettype none
package qpc_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int SQRT_STEPS   = 31;
    localparam int COEF_W       = 48;
    localparam int PRE_W        = 42;   // coefficient before scaling
    localparam int TAN_W        = 37;   // tangent, q.16
    localparam int CS_W         = 33;   // cordic datapath
    localparam int REM_W        = 63;   // square root remainder

    localparam logic signed [CS_W-1:0] CORDIC_GAIN = 33'sd652032874;

    // arctangent of 2^-i, full turn is 2^32
    localparam logic [31:0] ATAN [0:CORDIC_STEPS-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
        32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
        32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
        32'd20,        32'd10,        32'd5,         32'd3,        32'd1
    };

    typedef struct packed {
        logic signed [CS_W-1:0] x;
        logic signed [CS_W-1:0] y;
        logic signed [CS_W-1:0] z;
        logic [1:0]             quad;
    } t_cordic;

    typedef struct packed {
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [15:0] ex;
        logic signed [15:0] ey;
        logic [REM_W-1:0]   rem;
        logic [SQRT_STEPS-1:0] q;
        t_cordic            cs;
        t_cordic            ce;
    } t_stage;

endpackage
`default_nettype wire

// ===== src/quintic_path_coefficients.sv =====
// quintic_path_coefficients: pose pair to power-basis quintic coefficients
// depends on qpc_pkg
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    two poses in tdata
//  m_axis    out  m_axis_tvalid/m_axis_tready    coefficients, axis in tuser
//  cfg       in   i_cfg_valid/o_cfg_ready        inverse_field_scale
//
// the x result is sent first, then the y result from the same output register
// a new pose pair enters only when the output register is empty or sends y
// square root: 31 stages of one bit; cordic: 30 stages of one step, both ends
// a stall on m_axis freezes the whole pipeline; nothing is lost or repeated
// synchronous active-low reset clears valid bits and sets the scale register to 65536
`default_nettype none
module quintic_path_coefficients #(
    parameter int ANGLE_BITS     = 16,
    parameter int COEF_FRAC_BITS = 16
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // start_x, start_y, start_heading, end_x, end_y, end_heading
    input  wire  [95:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // coef_0, coef_1, coef_2, coef_3, coef_4, coef_5
    output logic [287:0] m_axis_tdata,
    // axis
    output logic         m_axis_tuser,
    output logic         m_axis_tlast,
    input  wire          i_cfg_valid,
    output logic         o_cfg_ready,
    input  wire  [23:0]  i_cfg_data
);

    localparam int NS = qpc_pkg::SQRT_STEPS;
    localparam int SH = 32 - COEF_FRAC_BITS;
    localparam int PW = qpc_pkg::PRE_W + 25;

    // 48-bit coefficient bounds
    localparam logic signed [PW-1:0] SAT_HI = PW'(48'sh7fff_ffff_ffff);
    localparam logic signed [PW-1:0] SAT_LO = PW'(48'sh8000_0000_0000);

    logic [23:0] r_scale;
    logic        adv;

    qpc_pkg::t_stage r_st [0:NS];
    logic            r_v  [0:NS];

    // tangent stage
    logic signed [qpc_pkg::TAN_W-1:0] r_t [0:1][0:1];    // [end][axis]
    logic signed [15:0]               r_tp [0:1][0:1];   // [end][axis] positions
    logic                             r_t_v;
    // pre-scale coefficients [axis][c0,c1,c3,c4,c5]
    logic signed [qpc_pkg::PRE_W-1:0] r_c [0:1][0:4];
    logic                             r_c_v;
    logic signed [PW-1:0]             r_m [0:1][0:4];
    logic                             r_m_v;
    logic signed [qpc_pkg::COEF_W-1:0] r_o [0:1][0:4];
    logic                             r_o_v;
    logic                             r_phase;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= 24'd65536;
        end else if (i_cfg_valid) begin
            r_scale <= i_cfg_data;
        end
    end

    assign adv           = !r_o_v || (m_axis_tready && r_phase);
    assign s_axis_tready = adv;

    // input stage: squared distance and cordic seed
    function automatic qpc_pkg::t_cordic seed(input logic [15:0] h);
        qpc_pkg::t_cordic c;
        logic [31:0]      a;
        a      = 32'((64'(h) & ((64'd1 << ANGLE_BITS) - 64'd1)) << (32 - ANGLE_BITS));
        c.x    = qpc_pkg::CORDIC_GAIN;
        c.y    = '0;
        c.z    = $signed({3'b000, a[29:0]});
        c.quad = a[31:30];
        return c;
    endfunction

    qpc_pkg::t_stage n_st0;
    always_comb begin
        logic signed [16:0] dx, dy;
        logic signed [33:0] px, py;
        logic [33:0]        d2;
        n_st0.sx = $signed(s_axis_tdata[15:0]);
        n_st0.sy = $signed(s_axis_tdata[31:16]);
        n_st0.ex = $signed(s_axis_tdata[63:48]);
        n_st0.ey = $signed(s_axis_tdata[79:64]);
        dx = 17'(n_st0.ex) - 17'(n_st0.sx);
        dy = 17'(n_st0.ey) - 17'(n_st0.sy);
        px = dx * dx;
        py = dy * dy;
        d2 = 34'(px) + 34'(py);
        n_st0.rem = qpc_pkg::REM_W'(d2) << 28;
        n_st0.q   = '0;
        n_st0.cs  = seed(s_axis_tdata[47:32]);
        n_st0.ce  = seed(s_axis_tdata[95:80]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (adv) begin
            r_v[0] <= s_axis_tvalid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_st[0] <= n_st0;
        end
    end

    function automatic qpc_pkg::t_cordic rot(input qpc_pkg::t_cordic c, input int i);
        qpc_pkg::t_cordic       r;
        logic signed [qpc_pkg::CS_W-1:0] xs, ys, at;
        xs = c.x >>> i;
        ys = c.y >>> i;
        at = $signed({1'b0, qpc_pkg::ATAN[i]});
        r  = c;
        if (c.z >= 0) begin
            r.x = c.x - ys; r.y = c.y + xs; r.z = c.z - at;
        end else begin
            r.x = c.x + ys; r.y = c.y - xs; r.z = c.z + at;
        end
        return r;
    endfunction

    // quadrant fold; x becomes cos and y sin
    function automatic qpc_pkg::t_cordic fold(input qpc_pkg::t_cordic c);
        qpc_pkg::t_cordic r;
        r = c;
        case (c.quad)
            2'd0: begin r.x = c.x;  r.y = c.y;  end
            2'd1: begin r.x = -c.y; r.y = c.x;  end
            2'd2: begin r.x = -c.x; r.y = -c.y; end
            default: begin r.x = c.y; r.y = -c.x; end
        endcase
        return r;
    endfunction

    for (genvar s = 1; s <= NS; s++) begin : g_stage
        localparam int I = NS - s;
        qpc_pkg::t_stage n_st;
        always_comb begin
            logic [qpc_pkg::REM_W-1:0] tr;
            n_st = r_st[s-1];
            tr   = (qpc_pkg::REM_W'(r_st[s-1].q) << (I + 1))
                 | (qpc_pkg::REM_W'(1) << (2 * I));
            if (r_st[s-1].rem >= tr) begin
                n_st.rem = r_st[s-1].rem - tr;
                n_st.q   = r_st[s-1].q | (NS'(1) << I);
            end
            if (s <= qpc_pkg::CORDIC_STEPS) begin
                n_st.cs = rot(r_st[s-1].cs, s - 1);
                n_st.ce = rot(r_st[s-1].ce, s - 1);
            end else begin
                n_st.cs = fold(r_st[s-1].cs);
                n_st.ce = fold(r_st[s-1].ce);
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (adv) begin
                r_v[s] <= r_v[s-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_st[s] <= n_st;
            end
        end
    end

    // tangents d * (cos, sin)
    function automatic logic signed [qpc_pkg::TAN_W-1:0] tang(
        input logic [NS-1:0] d, input logic signed [qpc_pkg::CS_W-1:0] c);
        logic signed [64:0] p;
        p = $signed({1'b0, d}) * c;
        return qpc_pkg::TAN_W'(p >>> 28);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_v <= 1'b0;
        end else if (adv) begin
            r_t_v <= r_v[NS];
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_t[0][0]  <= tang(r_st[NS].q, r_st[NS].cs.x);
            r_t[0][1]  <= tang(r_st[NS].q, r_st[NS].cs.y);
            r_t[1][0]  <= tang(r_st[NS].q, r_st[NS].ce.x);
            r_t[1][1]  <= tang(r_st[NS].q, r_st[NS].ce.y);
            r_tp[0][0] <= r_st[NS].sx;
            r_tp[0][1] <= r_st[NS].sy;
            r_tp[1][0] <= r_st[NS].ex;
            r_tp[1][1] <= r_st[NS].ey;
        end
    end

    // power basis in q.16 before scaling
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (adv) begin
            r_c_v <= r_t_v;
        end
    end
    for (genvar a = 0; a < 2; a++) begin : g_axis
        logic signed [qpc_pkg::PRE_W-1:0] p0, dd, t0, t1;
        assign p0 = qpc_pkg::PRE_W'(r_tp[0][a]) <<< 16;
        assign dd = (qpc_pkg::PRE_W'(r_tp[1][a]) - qpc_pkg::PRE_W'(r_tp[0][a])) <<< 16;
        assign t0 = qpc_pkg::PRE_W'(r_t[0][a]);
        assign t1 = qpc_pkg::PRE_W'(r_t[1][a]);
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_c[a][0] <= p0;
                r_c[a][1] <= t0;
                r_c[a][2] <= 42'sd10 * dd - 42'sd6 * t0 - 42'sd4 * t1;
                r_c[a][3] <= 42'sd8 * t0 + 42'sd7 * t1 - 42'sd15 * dd;
                r_c[a][4] <= 42'sd6 * dd - 42'sd3 * t0 - 42'sd3 * t1;
            end
        end
        for (genvar k = 0; k < 5; k++) begin : g_coef
            logic signed [PW-1:0] rs;
            logic signed [PW-1:0] sat;
            always_comb begin
                rs  = (r_m[a][k] + (PW'(1) <<< (SH - 1))) >>> SH;
                sat = rs;
                if (rs > SAT_HI) begin
                    sat = SAT_HI;
                end else if (rs < SAT_LO) begin
                    sat = SAT_LO;
                end
            end
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_m[a][k] <= PW'(r_c[a][k]) * $signed({1'b0, r_scale});
                    r_o[a][k] <= qpc_pkg::COEF_W'(sat);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v   <= 1'b0;
            r_o_v   <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            if (adv) begin
                r_m_v   <= r_c_v;
                r_o_v   <= r_m_v;
                r_phase <= 1'b0;
            end else if (m_axis_tready) begin
                // x transfer done, y is next
                r_phase <= 1'b1;
            end
        end
    end

    assign m_axis_tvalid = r_o_v;
    assign m_axis_tuser  = r_phase;
    assign m_axis_tlast  = r_phase;
    assign m_axis_tdata  = {r_o[r_phase][4], r_o[r_phase][3], r_o[r_phase][2],
                            qpc_pkg::COEF_W'(0), r_o[r_phase][1], r_o[r_phase][0]};

endmodule
`default_nettype wire

// ===== src/qpc_chk.sv =====
// qpc_chk: port-level assertions for quintic_path_coefficients
// depends on nothing but the top level's ports; bound to it below
`default_nettype none
module qpc_chk (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         m_axis_tvalid,
    input wire         m_axis_tready,
    input wire [287:0] m_axis_tdata,
    input wire         m_axis_tuser,
    input wire         m_axis_tlast
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");

    // y comes right after x
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tuser |=> m_axis_tvalid && m_axis_tuser)
        else $error("x not followed by y");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tlast == m_axis_tuser)
        else $error("tlast does not mark y");

    // quadratic term is always zero
    a_c2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[143:96] == 48'd0)
        else $error("nonzero quadratic term");

endmodule

bind quintic_path_coefficients qpc_chk u_qpc_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

// ===== tb/tb.sv =====
// tb: self-checking bench for quintic_path_coefficients, pose pairs in, x/y polynomials out
// depends on qpc_pkg (cordic gain and arctangent table) and the block itself
`timescale 1ns / 1ps
module tb;

    typedef struct packed {
        logic              axis;
        logic [5:0][47:0]  coef;
        logic              last;
    } t_poly;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [95:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [287:0] m_axis_tdata;
    logic         m_axis_tuser;
    logic         m_axis_tlast;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [23:0]  i_cfg_data = '0;

    logic [95:0] pose_q[$];
    t_poly       poly_q[$];
    logic [23:0] scale = 24'd65536;
    int          tx_idle = 13;
    int          rx_idle = 67;
    int          n_err = 0;

    quintic_path_coefficients u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic void add_pose(logic [95:0] p);
        pose_q.insert(pose_q.size(), p);
    endfunction

    function automatic void add_poly(t_poly r);
        poly_q.insert(poly_q.size(), r);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // q.30 cosine and sine of a binary angle
    task automatic heading_cos_sin(input logic [15:0] hd, output longint c, output longint s);
        logic [31:0] a;
        longint x, y, z, xs, ys;
        a = {hd, 16'b0};
        z = longint'(a[29:0]);
        x = longint'(qpc_pkg::CORDIC_GAIN);
        y = 0;
        for (int i = 0; i < qpc_pkg::CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys; y = y + xs; z = z - longint'(qpc_pkg::ATAN[i]);
            end else begin
                x = x + ys; y = y - xs; z = z + longint'(qpc_pkg::ATAN[i]);
            end
        end
        case (a[31:30])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endtask

    function automatic logic [47:0] scale_round_sat(longint v);
        longint p;
        p = (v * longint'({40'b0, scale}) + 64'sd32768) >>> 16;
        if (p > 64'sd140737488355327) p = 64'sd140737488355327;
        if (p < -64'sd140737488355328) p = -64'sd140737488355328;
        return p[47:0];
    endfunction

    function automatic t_poly axis_poly(logic ax, longint p0, longint p5, longint t0,
                                        longint t1);
        t_poly r;
        longint dd;
        dd = p5 - p0;
        r.axis = ax;
        r.last = ax;
        r.coef[0] = scale_round_sat(p0);
        r.coef[1] = scale_round_sat(t0);
        r.coef[2] = '0;
        r.coef[3] = scale_round_sat(10 * dd - 6 * t0 - 4 * t1);
        r.coef[4] = scale_round_sat(-15 * dd + 8 * t0 + 7 * t1);
        r.coef[5] = scale_round_sat(6 * dd - 3 * t0 - 3 * t1);
        return r;
    endfunction

    task automatic predict_path(input logic [95:0] p);
        longint sx, sy, ex, ey, dx, dy, d14, cs, ss, ce, se;
        longint unsigned d2;
        sx = longint'($signed(p[15:0]));
        sy = longint'($signed(p[31:16]));
        ex = longint'($signed(p[63:48]));
        ey = longint'($signed(p[79:64]));
        dx = ex - sx;
        dy = ey - sy;
        d2 = dx * dx + dy * dy;
        d14 = longint'(int_sqrt(d2 << 28));
        heading_cos_sin(p[47:32], cs, ss);
        heading_cos_sin(p[95:80], ce, se);
        add_poly(axis_poly(1'b0, sx * 65536, ex * 65536,
                           (d14 * cs) >>> 28, (d14 * ce) >>> 28));
        add_poly(axis_poly(1'b1, sy * 65536, ey * 65536,
                           (d14 * ss) >>> 28, (d14 * se) >>> 28));
    endtask

    // pose driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (pose_q.size() > 0 && $urandom_range(99) >= tx_idle) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= pose_q.pop_front();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= i_rst_n && ($urandom_range(99) >= rx_idle);
    end

    // monitor: predict on input transfers, check output transfers
    always @(posedge i_clk) begin
        t_poly got, want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                predict_path(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) begin
                got.axis = m_axis_tuser;
                got.last = m_axis_tlast;
                got.coef = m_axis_tdata;
                if (poly_q.size() == 0) begin
                    $error("unexpected result transfer");
                    n_err++;
                end else begin
                    want = poly_q.pop_front();
                    if (got.axis !== want.axis) begin
                        $error("axis: expected %0d, got %0d", want.axis, got.axis);
                        n_err++;
                    end
                    if (got.last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, got.last);
                        n_err++;
                    end
                    for (int k = 0; k < 6; k++)
                        if (got.coef[k] !== want.coef[k]) begin
                            $error("coef_%0d: expected %0d, got %0d", k,
                                   $signed(want.coef[k]), $signed(got.coef[k]));
                            n_err++;
                        end
                end
            end
        end
    end

    function automatic logic [95:0] pose(logic [15:0] sx, logic [15:0] sy, logic [15:0] sh,
                                         logic [15:0] ex, logic [15:0] ey, logic [15:0] eh);
        return {eh, ey, ex, sh, sy, sx};
    endfunction

    function automatic logic [15:0] rand_coord();
        logic [15:0] v;
        v = 16'($urandom);
        // mostly nearby points, sometimes full range
        if ($urandom_range(3) != 0) v = 16'($signed(v) >>> $urandom_range(15));
        return v;
    endfunction

    task automatic add_random(int n);
        logic [15:0] sx, sy;
        for (int i = 0; i < n; i++) begin
            sx = 16'($urandom);
            sy = 16'($urandom);
            if ($urandom_range(3) != 0)
                add_pose(pose(sx, sy, 16'($urandom), sx + rand_coord(), sy + rand_coord(),
                              16'($urandom)));
            else
                add_pose({$urandom, $urandom, $urandom});
        end
    endtask

    task automatic wait_drained();
        while (pose_q.size() > 0 || s_axis_tvalid || poly_q.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_scale(logic [23:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        scale = v;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, quadrant headings, equal positions
        add_pose(pose(16'h8000, 16'h8000, 16'd0, 16'h7fff, 16'h7fff, 16'hffff));
        add_pose(pose(16'h7fff, 16'h7fff, 16'hffff, 16'h8000, 16'h8000, 16'd0));
        add_pose(pose(16'h8000, 16'h7fff, 16'd16384, 16'h7fff, 16'h8000, 16'd49152));
        add_pose(pose(16'd100, 16'd200, 16'd0, 16'd100, 16'd200, 16'd32768));
        add_pose(pose(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
        add_pose(pose(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
        for (int q = 0; q < 8; q++)
            add_pose(pose(16'd0, 16'd0, 16'(q * 8192), 16'd1000, 16'hfc18,
                          16'(q * 8192 + 1)));
        wait_drained();

        write_scale(24'd1);
        add_pose(pose(16'h8000, 16'h8000, 16'd8192, 16'h7fff, 16'h7fff, 16'd24576));
        tx_idle = 13;
        rx_idle = 67;
        add_random(350);
        wait_drained();

        write_scale(24'hffffff);
        add_pose(pose(16'h8000, 16'h8000, 16'd8192, 16'h7fff, 16'h7fff, 16'd24576));
        add_pose(pose(16'h7fff, 16'h8000, 16'd40000, 16'h8000, 16'h7fff, 16'd1));
        tx_idle = 67;
        rx_idle = 13;
        add_random(350);
        wait_drained();

        // zero scale yields all-zero coefficients
        write_scale(24'd0);
        add_random(30);
        wait_drained();

        write_scale(24'($urandom));
        tx_idle = 0;
        rx_idle = 0;
        add_random(200);
        wait_drained();

        write_scale(24'd65536);
        add_random(150);
        wait_drained();

        if (n_err == 0 && poly_q.size() == 0) begin
            $display("quintic_path_coefficients: match");
        end else begin
            $display("quintic_path_coefficients: mismatch");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("quintic_path_coefficients: mismatch");
        $finish;
    end
endmodule

// ===== sim.f =====
src/qpc_pkg.sv
src/quintic_path_coefficients.sv
src/qpc_chk.sv
tb/tb.sv
